// ===== src/csd_pkg.sv =====
// csd_pkg: shared types and constants for the can signal decoder
// holds the config, frame, result and queue word layouts; no dependencies
package csd_pkg;

  localparam int FRAME_BYTES = 8;
  localparam logic [2:0] HIGH_BYTE = 3'd7;
  localparam logic [3:0] MAX_LENGTH = 4'd8;
  localparam logic [6:0] MAX_WIDTH = 7'd64;
  localparam int SUM_W = 98;
  localparam logic signed [47:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    CAUSE_OK,
    CAUSE_MISSING,
    CAUSE_NEGATIVE,
    CAUSE_RANGE
  } csd_cause_t;

  typedef enum logic [2:0] {
    REG_START,
    REG_WIDTH,
    REG_ORDER,
    REG_SIGNED,
    REG_SCALE,
    REG_OFFSET,
    REG_LOWER,
    REG_UPPER
  } csd_reg_t;

  typedef struct packed {
    logic [5:0]         start_position;
    logic [6:0]         signal_width;
    logic               motorola_order;
    logic               signed_signal;
    logic signed [31:0] scale_factor;
    logic signed [47:0] offset_value;
    logic signed [47:0] lower_limit;
    logic signed [47:0] upper_limit;
  } csd_cfg_t;

  typedef struct packed {
    logic [63:0] frame_bytes;
    logic [3:0]  frame_length;
  } csd_frame_t;

  typedef struct packed {
    logic               accepted;
    csd_cause_t         fail_cause;
    logic signed [47:0] physical_value;
    logic [63:0]        raw_value;
  } csd_result_t;

  typedef struct packed {
    csd_cause_t  cause;
    logic [63:0] raw;
    logic        neg;
    logic [63:0] mag;
  } csd_item_t;

endpackage

// ===== src/csd_regs.sv =====
// csd_regs: apb-style configuration register file
// depends on csd_pkg for the register index codes and the config struct
module csd_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output csd_pkg::csd_cfg_t  cfg
);
  import csd_pkg::*;

  logic     wr_en;
  csd_reg_t idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign idx = csd_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_position <= 6'd0;
      cfg.signal_width <= 7'd8;
      cfg.motorola_order <= 1'b0;
      cfg.signed_signal <= 1'b0;
      cfg.scale_factor <= 32'sd65536;
      cfg.offset_value <= 48'sd0;
      cfg.lower_limit <= Q_MIN;
      cfg.upper_limit <= Q_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_START:  cfg.start_position <= pwdata[5:0];
        REG_WIDTH:  cfg.signal_width <= pwdata[6:0];
        REG_ORDER:  cfg.motorola_order <= pwdata[0];
        REG_SIGNED: cfg.signed_signal <= pwdata[0];
        REG_SCALE:  cfg.scale_factor <= pwdata[31:0];
        REG_OFFSET: cfg.offset_value <= pwdata[47:0];
        REG_LOWER:  cfg.lower_limit <= pwdata[47:0];
        REG_UPPER:  cfg.upper_limit <= pwdata[47:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START:  prdata = {58'd0, cfg.start_position};
      REG_WIDTH:  prdata = {57'd0, cfg.signal_width};
      REG_ORDER:  prdata = {63'd0, cfg.motorola_order};
      REG_SIGNED: prdata = {63'd0, cfg.signed_signal};
      REG_SCALE:  prdata = {32'd0, cfg.scale_factor};
      REG_OFFSET: prdata = {16'd0, cfg.offset_value};
      REG_LOWER:  prdata = {16'd0, cfg.lower_limit};
      REG_UPPER:  prdata = {16'd0, cfg.upper_limit};
    endcase
  end

endmodule

// ===== src/csd_front.sv =====
// csd_front: classifies a frame, cuts out the raw signal and its magnitude
// depends on csd_pkg for the frame, config and queue word types
module csd_front (
  input  csd_pkg::csd_cfg_t   cfg,
  input  csd_pkg::csd_frame_t frame,
  output csd_pkg::csd_item_t  item
);
  import csd_pkg::*;

  logic [6:0]  len;
  logic [3:0]  dlc;
  logic [7:0]  last;
  logic [6:0]  sp1;
  logic [5:0]  lowest;
  logic [2:0]  moto_byte;
  logic [5:0]  shamt;
  logic [5:0]  top_bit;
  logic [63:0] swapped;
  logic [63:0] src;
  logic [63:0] mask;
  logic [63:0] raw;
  logic [63:0] ext;
  logic        neg;
  csd_cause_t  cause;

  always_comb begin
    len = (cfg.signal_width > MAX_WIDTH) ? MAX_WIDTH : cfg.signal_width;
    dlc = (frame.frame_length > MAX_LENGTH) ? MAX_LENGTH : frame.frame_length;
    last = {2'b00, cfg.start_position} + {1'b0, len} - 8'd1;
    sp1 = {1'b0, cfg.start_position} + 7'd1;
    lowest = (sp1 >= len) ? 6'(sp1 - len) : 6'd0;
    moto_byte = HIGH_BYTE - lowest[5:3];
    for (int j = 0; j < FRAME_BYTES; j++) begin
      swapped[8*j +: 8] = frame.frame_bytes[8*(FRAME_BYTES-1-j) +: 8];
    end
    mask = (len == MAX_WIDTH) ? '1 : ((64'd1 << len) - 64'd1);

    cause = CAUSE_OK;
    if (len != 7'd0) begin
      if (!cfg.motorola_order) begin
        if (last[7:3] >= {1'b0, dlc}) cause = CAUSE_MISSING;
      end else if ({1'b0, moto_byte} >= dlc) begin
        cause = CAUSE_MISSING;
      end else if (sp1 < len) begin
        cause = CAUSE_NEGATIVE;
      end
    end

    // motorola numbering is the byte-swapped frame read from the lowest bit up
    src = cfg.motorola_order ? swapped : frame.frame_bytes;
    shamt = cfg.motorola_order ? lowest : cfg.start_position;
    raw = (cause == CAUSE_OK) ? ((src >> shamt) & mask) : 64'd0;

    top_bit = 6'(len - 7'd1);
    neg = cfg.signed_signal && (len != 7'd0) && raw[top_bit];
    ext = raw | ~mask;

    item.cause = cause;
    item.raw = raw;
    item.neg = neg;
    item.mag = neg ? (~ext + 64'd1) : raw;
  end

endmodule

// ===== src/csd_queue.sv =====
// csd_queue: short fifo of classified words between front and back
// depends on csd_pkg for the queue word type
module csd_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csd_pkg::csd_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output csd_pkg::csd_item_t item
);
  import csd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  csd_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == FULL_CNT);
  assign valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && valid;
  assign item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/csd_back.sv =====
// csd_back: scaling pipeline, offset, saturation and limit check
// depends on csd_pkg for config, queue word and result types
module csd_back (
  input  logic                clk,
  input  logic                rst,
  input  csd_pkg::csd_cfg_t   cfg,
  input  logic                in_valid,
  input  csd_pkg::csd_item_t  in_item,
  output logic                in_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output csd_pkg::csd_result_t result
);
  import csd_pkg::*;

  typedef struct packed {
    csd_cause_t  cause;
    logic [63:0] raw;
  } tag_t;

  logic        fneg;
  logic [31:0] fmag;
  logic [63:0] lo_prod;
  logic [63:0] hi_prod;
  logic [95:0] prod;
  logic signed [SUM_W-1:0] off_ext;
  logic signed [SUM_W-1:0] prod_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [47:0] phys_sat;
  csd_result_t res_next;

  logic        rdy1, rdy2, rdy3, rdy4, rdy5;

  logic        s1_valid;
  logic [63:0] s1_lo;
  logic [31:0] s1_mag_hi;
  logic [31:0] s1_fmag;
  logic        s1_minus;
  tag_t        s1_tag;

  logic        s2_valid;
  logic [63:0] s2_lo;
  logic [63:0] s2_hi;
  logic        s2_minus;
  tag_t        s2_tag;

  logic        s3_valid;
  logic [95:0] s3_prod;
  logic        s3_minus;
  tag_t        s3_tag;

  logic        s4_valid;
  logic signed [47:0] s4_phys;
  tag_t        s4_tag;

  assign rdy5 = !result_valid || result_ready;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    fneg = cfg.scale_factor[31];
    fmag = fneg ? (~cfg.scale_factor + 32'd1) : cfg.scale_factor;
    lo_prod = 64'(in_item.mag[31:0]) * 64'(fmag);
    hi_prod = 64'(s1_mag_hi) * 64'(s1_fmag);
    prod = {s2_hi, 32'd0} + {32'd0, s2_lo};

    off_ext = SUM_W'(cfg.offset_value);
    prod_ext = $signed({2'b00, s3_prod});
    sum = s3_minus ? (off_ext - prod_ext) : (off_ext + prod_ext);
    if ((&sum[SUM_W-1:47]) || !(|sum[SUM_W-1:47])) begin
      phys_sat = sum[47:0];
    end else begin
      phys_sat = sum[SUM_W-1] ? Q_MIN : Q_MAX;
    end

    priority if (s4_tag.cause != CAUSE_OK) begin
      res_next.accepted = 1'b0;
      res_next.fail_cause = s4_tag.cause;
      res_next.physical_value = '0;
      res_next.raw_value = '0;
    end else if ((s4_phys < cfg.lower_limit) || (s4_phys > cfg.upper_limit)) begin
      res_next.accepted = 1'b0;
      res_next.fail_cause = CAUSE_RANGE;
      res_next.physical_value = '0;
      res_next.raw_value = s4_tag.raw;
    end else begin
      res_next.accepted = 1'b1;
      res_next.fail_cause = CAUSE_OK;
      res_next.physical_value = s4_phys;
      res_next.raw_value = s4_tag.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= in_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
      if (rdy5) result_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_lo <= lo_prod;
      s1_mag_hi <= in_item.mag[63:32];
      s1_fmag <= fmag;
      s1_minus <= in_item.neg ^ fneg;
      s1_tag <= '{cause: in_item.cause, raw: in_item.raw};
    end
    if (rdy2 && s1_valid) begin
      s2_lo <= s1_lo;
      s2_hi <= hi_prod;
      s2_minus <= s1_minus;
      s2_tag <= s1_tag;
    end
    if (rdy3 && s2_valid) begin
      s3_prod <= prod;
      s3_minus <= s2_minus;
      s3_tag <= s2_tag;
    end
    if (rdy4 && s3_valid) begin
      s4_phys <= phys_sat;
      s4_tag <= s3_tag;
    end
    if (rdy5 && s4_valid) begin
      result <= res_next;
    end
  end

endmodule

// ===== src/can_signal_decode.sv =====
// can_signal_decode: top level of the can signal decoder
// depends on csd_pkg, csd_regs, csd_front, csd_queue and csd_back
//
//   channel   direction  handshake                  word
//   config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//   frame     in         frame_valid/frame_ready     csd_frame_t
//   result    out        result_valid/result_ready   csd_result_t
//
// one frame per cycle unless a stalled result backs up; frames pass the queue
// the front classifies in the accept cycle, the back runs 5 register stages
// (two 32x32 partial products, combine, offset and saturate, limit check)
// reset clears the queue and pipeline valids and loads the register defaults
// a stalled result fills the pipeline, then the queue, then drops frame_ready
module can_signal_decode #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [5:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready,
  input  logic                 frame_valid,
  output logic                 frame_ready,
  input  csd_pkg::csd_frame_t  frame,
  output logic                 result_valid,
  input  logic                 result_ready,
  output csd_pkg::csd_result_t result
);
  import csd_pkg::*;

  csd_cfg_t  cfg;
  csd_item_t front_item;
  csd_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      back_ready;

  assign frame_ready = !q_full;

  csd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csd_front u_front (
    .cfg   (cfg),
    .frame (frame),
    .item  (front_item)
  );

  csd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (frame_valid && frame_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (back_ready),
    .valid     (q_valid),
    .item      (q_item)
  );

  csd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (q_valid),
    .in_item      (q_item),
    .in_ready     (back_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== src/csd_checker.sv =====
// csd_checker: port-level assertions for can_signal_decode
// depends on csd_pkg; bound to the top level at the end of this file
module csd_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 frame_valid,
  input logic                 frame_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input csd_pkg::csd_result_t result
);
  import csd_pkg::*;

  logic [7:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc = frame_valid && frame_ready;
  assign out_acc = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 8'd0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 8'd1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 8'd1;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 8'd0)
    else $error("result word without a pending frame");

  a_accept_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.accepted == (result.fail_cause == CAUSE_OK))
    else $error("accepted flag disagrees with fail cause");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.fail_cause == CAUSE_MISSING || result.fail_cause == CAUSE_NEGATIVE)
    |-> result.raw_value == 64'd0 && result.physical_value == 48'sd0)
    else $error("decode failure carries nonzero value");

endmodule

bind can_signal_decode csd_checker u_csd_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_ready  (frame_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
